/* rtl/core/kwm_pkg.sv */
// kwm_pkg: shared types and constants for the k-way sorted list merge unit.
// No dependencies; used by rtl/core/k_way_sorted_list_merge_unit.sv.

package kwm_pkg;

  // Beat field widths
  localparam int DATA_W     = 32;
  localparam int LIST_NUM_W = 3;
  localparam int CNT_W      = 8;

  // Saturation point of the drop counter
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_MERGE  = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

/* rtl/core/k_way_sorted_list_merge_unit.sv */
// k_way_sorted_list_merge_unit: element store, list bookkeeping and merge sequencer.
// Depends on rtl/core/kwm_pkg.sv.

// On an append beat the value goes to the tail of its list or is
// dropped and counted (list number out of range, list full, or smaller than the
// list's tail). A merge beat keeps busy high while it walks the list heads with
// one comparator fed by the single read port of the element store: for each
// merged value the sequencer scans the heads through the registered read, then
// emits the winner. A merge with nothing stored gives its one empty result
// without going busy. Results come out one per out_valid pulse and cannot be
// stalled; the last value of a merge carries out_last, and all lists and the
// drop counter are cleared after it.

module k_way_sorted_list_merge_unit #(
  parameter int LISTS      = 8,
  parameter int LIST_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic [kwm_pkg::LIST_NUM_W-1:0]       in_list_number,
  input  logic signed [kwm_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  output logic signed [kwm_pkg::DATA_W-1:0]    out_merged_value,
  output logic                                 out_last,
  output logic                                 out_empty_res,
  output logic [kwm_pkg::CNT_W-1:0]            out_dropped_count
);
  import kwm_pkg::*;

  localparam int SLOTS  = LISTS * LIST_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int LIDX_W = $clog2(LISTS);
  localparam int POS_W  = $clog2(LIST_DEPTH + 1);
  localparam int TOT_W  = $clog2(SLOTS + 1);
  localparam int SI_W   = $clog2(LISTS + 1);

  // Store address of a list position
  function automatic logic [ADDR_W-1:0] slot_of(input logic [LIDX_W-1:0] l,
                                                 input logic [POS_W-1:0]  p);
    slot_of = ADDR_W'(l) * ADDR_W'(LIST_DEPTH) + ADDR_W'(p);
  endfunction

  // Control state
  state_t                 state_r, state_nxt;
  logic [POS_W-1:0]       fill_r [LISTS];
  logic [POS_W-1:0]       fill_nxt [LISTS];
  logic [POS_W-1:0]       head_r [LISTS];
  logic [POS_W-1:0]       head_nxt [LISTS];
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [TOT_W-1:0]       remain_r, remain_nxt;
  logic [CNT_W-1:0]       drop_r, drop_nxt;
  logic [SI_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic                   found_r, found_nxt;
  logic                   rd_req_r, rd_req_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Payload state
  logic signed [DATA_W-1:0] mem [SLOTS];
  logic signed [DATA_W-1:0] tail_r [LISTS];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [LIDX_W-1:0]        rd_list_r, rd_list_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  logic [LIDX_W-1:0]        best_list_r, best_list_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic [CNT_W-1:0]         out_drop_r, out_drop_nxt;

  // Store access
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   tail_we;

  logic                   accept;
  logic                   list_ok;
  logic [LIDX_W-1:0]      in_lidx;
  logic [LIDX_W-1:0]      scan_lidx;
  logic [POS_W-1:0]       in_fill;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign list_ok   = (int'(in_list_number) < LISTS);
  assign in_lidx   = in_list_number[LIDX_W-1:0];
  assign scan_lidx = scan_idx_r[LIDX_W-1:0];
  assign in_fill   = fill_r[in_lidx];

  // Sequencer and bookkeeping
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    remain_nxt    = remain_r;
    drop_nxt      = drop_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    rd_req_nxt    = 1'b0;
    rd_list_nxt   = rd_list_r;
    best_val_nxt  = best_val_r;
    best_list_nxt = best_list_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_drop_nxt  = out_drop_r;
    mem_we        = 1'b0;
    tail_we       = 1'b0;
    mem_waddr     = slot_of(in_lidx, in_fill);
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_APPEND: begin
              if (!list_ok || in_fill == POS_W'(LIST_DEPTH) ||
                  (in_fill != '0 && in_value < tail_r[in_lidx])) begin
                if (drop_r != CNT_MAX) drop_nxt = drop_r + 1'b1;
              end else begin
                mem_we            = 1'b1;
                tail_we           = 1'b1;
                fill_nxt[in_lidx] = in_fill + 1'b1;
                total_nxt         = total_r + 1'b1;
              end
            end
            CMD_MERGE: begin
              if (total_r == '0) begin
                // nothing stored: one empty beat
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                out_last_nxt  = 1'b1;
                out_empty_nxt = 1'b1;
                out_drop_nxt  = drop_r;
                drop_nxt      = '0;
              end else begin
                state_nxt    = ST_SCAN;
                scan_idx_nxt = '0;
                found_nxt    = 1'b0;
                remain_nxt   = total_r;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // issue stage: read the head of one list
        if (scan_idx_r < SI_W'(LISTS)) begin
          rd_req_nxt  = (head_r[scan_lidx] < fill_r[scan_lidx]);
          rd_list_nxt = scan_lidx;
          rd_addr     = rd_req_nxt ? slot_of(scan_lidx, head_r[scan_lidx]) : '0;
        end else begin
          state_nxt = ST_EMIT;
        end
        scan_idx_nxt = scan_idx_r + 1'b1;
        // compare stage: strict less keeps the lowest list on ties
        if (rd_req_r && (!found_r || rd_data_r < best_val_r)) begin
          found_nxt     = 1'b1;
          best_val_nxt  = rd_data_r;
          best_list_nxt = rd_list_r;
        end
      end

      ST_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_value_nxt         = best_val_r;
        out_empty_nxt         = 1'b0;
        out_drop_nxt          = drop_r;
        out_last_nxt          = (remain_r == TOT_W'(1));
        head_nxt[best_list_r] = head_r[best_list_r] + 1'b1;
        remain_nxt            = remain_r - 1'b1;
        if (remain_r == TOT_W'(1)) begin
          // run done: clear all lists
          for (int i = 0; i < LISTS; i++) begin
            fill_nxt[i] = '0;
            head_nxt[i] = '0;
          end
          total_nxt = '0;
          drop_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      for (int i = 0; i < LISTS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
      total_r     <= '0;
      remain_r    <= '0;
      drop_r      <= '0;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      rd_req_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      remain_r    <= remain_nxt;
      drop_r      <= drop_nxt;
      scan_idx_r  <= scan_idx_nxt;
      found_r     <= found_nxt;
      rd_req_r    <= rd_req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_list_r   <= rd_list_nxt;
    best_val_r  <= best_val_nxt;
    best_list_r <= best_list_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_drop_r  <= out_drop_nxt;
    if (tail_we) tail_r[in_lidx] <= in_value;
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= in_value;
    if (rd_req_nxt) rd_data_r <= mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_merged_value  = out_value_r;
  assign out_last          = out_last_r;
  assign out_empty_res     = out_empty_r;
  assign out_dropped_count = out_drop_r;

  // Checks
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last)
    else $error("empty beat without last");

  a_emit_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> found_r)
    else $error("emit with no candidate head");

  a_empty_merge: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_MERGE && total_r == '0 |=> out_valid && out_empty_res)
    else $error("empty merge gave no empty beat");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> state_r == ST_SCAN)
    else $error("merge run stopped before last beat");

endmodule

/* tb/k_way_sorted_list_merge_unit_tb.sv */
// Self-checking testbench for k_way_sorted_list_merge_unit: appends, drops and merge runs.
// Depends on rtl/core/kwm_pkg.sv and rtl/core/k_way_sorted_list_merge_unit.sv.
`timescale 1ns / 1ps

module k_way_sorted_list_merge_unit_tb;
  import kwm_pkg::*;

  localparam int LISTS      = 8;
  localparam int LIST_DEPTH = 8;
  // Quiet cycles allowed before the watchdog gives up
  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
    logic                     empty_res;
    logic [CNT_W-1:0]         dropped_count;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_APPEND;
  logic [LIST_NUM_W-1:0] in_list_number = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic out_valid;
  logic signed [DATA_W-1:0] out_merged_value;
  logic out_last;
  logic out_empty_res;
  logic [CNT_W-1:0] out_dropped_count;

  // Shadow copy of the list contents and drop counter
  logic signed [DATA_W-1:0] shadow_lists [LISTS][LIST_DEPTH];
  int unsigned shadow_fill [LISTS];
  logic [CNT_W-1:0] shadow_drops = '0;

  merge_result_t merged_q [$];

  int error_count = 0;
  int beats_sent = 0;
  int merges_sent = 0;
  int empty_merges = 0;
  int values_checked = 0;
  int longest_run = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  always #5 clk = ~clk;

  k_way_sorted_list_merge_unit #(
    .LISTS(LISTS),
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_list_number(in_list_number),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_merged_value(out_merged_value),
    .out_last(out_last),
    .out_empty_res(out_empty_res),
    .out_dropped_count(out_dropped_count)
  );

  // Update the shadow lists for one accepted beat and queue the merge output
  function automatic void predict_merge_output(input logic cmd, input logic [LIST_NUM_W-1:0] lst,
                                               input logic signed [DATA_W-1:0] val);
    int unsigned head [LISTS];
    int unsigned total;
    int best;
    merge_result_t r;
    beats_sent++;
    if (cmd == CMD_APPEND) begin
      // out-of-range list, full list or value below the tail: drop and count
      if (lst >= LISTS || shadow_fill[lst] >= LIST_DEPTH ||
          (shadow_fill[lst] > 0 && val < shadow_lists[lst][shadow_fill[lst]-1])) begin
        if (shadow_drops != CNT_MAX) shadow_drops++;
      end else begin
        shadow_lists[lst][shadow_fill[lst]] = val;
        shadow_fill[lst]++;
      end
      return;
    end
    merges_sent++;
    total = 0;
    foreach (shadow_fill[i]) begin
      head[i] = 0;
      total += shadow_fill[i];
    end
    r.empty_res = 1'b0;
    r.dropped_count = shadow_drops;
    if (total == 0) begin
      empty_merges++;
      r.merged_value = '0;
      r.last = 1'b1;
      r.empty_res = 1'b1;
      merged_q.push_back(r);
    end else begin
      if (total > longest_run) longest_run = total;
      for (int n = 0; n < total; n++) begin
        // smallest head wins, lowest list number on a tie
        best = -1;
        for (int i = 0; i < LISTS; i++) begin
          if (head[i] < shadow_fill[i] &&
              (best < 0 || shadow_lists[i][head[i]] < shadow_lists[best][head[best]]))
            best = i;
        end
        r.merged_value = shadow_lists[best][head[best]];
        r.last = (n == total - 1);
        head[best]++;
        merged_q.push_back(r);
      end
    end
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    shadow_drops = '0;
  endfunction

  // Drive one beat, idling cycle by cycle at the current rate, and wait until accepted
  task automatic send_beat(input logic cmd, input logic [LIST_NUM_W-1:0] lst,
                           input logic signed [DATA_W-1:0] val);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_list_number <= lst;
    in_value <= val;
    do @(posedge clk); while (busy);
    predict_merge_output(cmd, lst, val);
  endtask

  // Output checker and watchdog
  always @(posedge clk) begin
    merge_result_t want;
    if ((start && !busy) || (rst_n && out_valid)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (merged_q.size() == 0) begin
        $error("unexpected result beat, merged_value %0d", out_merged_value);
        error_count++;
      end else begin
        want = merged_q.pop_front();
        values_checked++;
        if (out_merged_value !== want.merged_value) begin
          $error("merged_value: expected %0d, got %0d", want.merged_value, out_merged_value);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          error_count++;
        end
        if (out_empty_res !== want.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want.empty_res, out_empty_res);
          error_count++;
        end
        if (out_dropped_count !== want.dropped_count) begin
          $error("dropped_count: expected %0d, got %0d", want.dropped_count,
                 out_dropped_count);
          error_count++;
        end
      end
    end
  end

  // Merge with nothing stored; list number and value must be ignored
  task automatic test_empty_merge();
    send_beat(CMD_MERGE, 3'd7, -32'sd1);
  endtask

  // Extreme values, equal values kept, out-of-order values dropped
  task automatic test_value_extremes();
    send_beat(CMD_APPEND, 3'd0, 32'sh8000_0000);
    send_beat(CMD_APPEND, 3'd0, 32'sh8000_0000);
    send_beat(CMD_APPEND, 3'd0, 32'sh7fff_ffff);
    send_beat(CMD_APPEND, 3'd7, 32'sh7fff_ffff);
    send_beat(CMD_APPEND, 3'd7, 32'sh8000_0000);
    send_beat(CMD_APPEND, 3'd1, 32'sd0);
    send_beat(CMD_APPEND, 3'd1, -32'sd1);
    send_beat(CMD_APPEND, 3'd1, 32'sd0);
    send_beat(CMD_APPEND, 3'd5, 32'sh5555_5555);
    send_beat(CMD_APPEND, 3'd6, 32'shaaaa_aaaa);
    send_beat(CMD_MERGE, 3'd0, 32'sd0);
  endtask

  // Fill one list, overflow it, and tie a value with another list
  task automatic test_full_list();
    for (int k = 0; k < LIST_DEPTH; k++) send_beat(CMD_APPEND, 3'd3, k);
    send_beat(CMD_APPEND, 3'd3, 32'sd100);
    send_beat(CMD_APPEND, 3'd4, 32'sd3);
    send_beat(CMD_MERGE, 3'd5, 32'sh1234_5678);
  endtask

  // Push the drop counter past saturation, then check it clears on merge
  task automatic test_drop_saturation();
    for (int k = 0; k < LIST_DEPTH; k++) send_beat(CMD_APPEND, 3'd2, k * 1000);
    for (int k = 0; k < 257; k++)
      send_beat(CMD_APPEND, 3'd2, (k % 2) ? 32'sd5000 : -32'sd7);
    send_beat(CMD_MERGE, 3'd2, 32'sd0);
    send_beat(CMD_MERGE, 3'd2, 32'sd0);
  endtask

  // Mostly sorted appends with random content, some noise, then a merge;
  // the beat count stops exactly at n_beats
  task automatic test_random_merges(input int idle_pct, input int n_beats);
    int sent;
    int n_app;
    int l;
    bit full_set;
    longint tail;
    longint step;
    longint nxt;
    logic signed [DATA_W-1:0] val;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_beats) begin
      full_set = (n_beats - sent >= LISTS * LIST_DEPTH + 2) && ($urandom_range(7) == 0);
      n_app = full_set ? LISTS * LIST_DEPTH : $urandom_range(0, 24);
      if (!full_set && n_app > n_beats - sent - 1) n_app = n_beats - sent - 1;
      for (int k = 0; k < n_app; k++) begin
        if (!full_set && $urandom_range(99) < 15) begin
          send_beat(CMD_APPEND, LIST_NUM_W'($urandom), $urandom);
        end else begin
          do l = $urandom_range(LISTS - 1); while (full_set && shadow_fill[l] >= LIST_DEPTH);
          if (shadow_fill[l] == 0) begin
            val = $urandom;
          end else begin
            tail = shadow_lists[l][shadow_fill[l]-1];
            case ($urandom_range(3))
              0: step = 0;
              1: step = $urandom_range(1, 100);
              default: step = $urandom_range(1, 1 << 28);
            endcase
            nxt = tail + step;
            if (nxt > 64'sd2147483647) nxt = tail;
            val = nxt[DATA_W-1:0];
          end
          send_beat(CMD_APPEND, LIST_NUM_W'(l), val);
        end
        sent++;
      end
      // every list is full here, so this one is dropped
      if (full_set) begin
        send_beat(CMD_APPEND, LIST_NUM_W'($urandom), $urandom);
        sent++;
      end
      send_beat(CMD_MERGE, LIST_NUM_W'($urandom), $urandom);
      sent++;
    end
  endtask

  initial begin
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles about a quarter of the time
    sender_idle_pct = 26;
    test_empty_merge();
    test_value_extremes();
    test_full_list();
    test_random_merges(26, 7);

    // sender idles most of the time
    sender_idle_pct = 62;
    test_drop_saturation();
    test_random_merges(62, 7);

    // no idling
    test_random_merges(0, 7);

    start <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk);
    repeat (2 * (LISTS + 2)) @(posedge clk);

    $display("Sent %0d beats with %0d merges (%0d empty); checked %0d merged values,",
             beats_sent, merges_sent, empty_merges, values_checked);
    $display("longest merge run %0d values, drop counter taken to saturation.", longest_run);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
